### rtl/shamh_pkg.sv
// Shared types, constants and round functions for the SHA-256 message hasher.
package shamh_pkg;

    // Eight-word chaining value and sixteen-word message block, word 0 first.
    typedef logic [7:0][31:0]  t_hash;
    typedef logic [15:0][31:0] t_blk;

    // Control from the byte sequencer to the compression unit.
    typedef struct packed {
        logic start;  // load a block and run 64 rounds
        logic init;   // return the chaining value to the initial hash
    } t_core_ctl;

    // Initial hash values, word 0 in the lowest slot.
    localparam t_hash HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] PAD_STOP = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD = 3'd7;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned amt);
        rotr = (x >> amt) | (x << (32 - amt));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Round constant table.
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        round_k = k;
    endfunction

endpackage

### rtl/shamh_core.sv
// SHA-256 compression unit: one round per cycle over a sixteen-word schedule window.
module shamh_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  shamh_pkg::t_core_ctl i_ctl,
    input  shamh_pkg::t_blk      i_block,
    output logic                 o_busy,
    output shamh_pkg::t_hash     o_hash
);
    import shamh_pkg::*;

    t_hash       r_hash;
    t_hash       r_s;
    t_blk        r_w;
    logic [5:0]  r_round;
    logic        r_busy;
    logic        r_fin;

    logic [31:0] n_w_new;
    logic [31:0] n_tmp1;
    logic [31:0] n_tmp2;
    logic [31:0] n_choose;
    logic [31:0] n_major;

    // Round datapath: the shared adder tree for one round and one schedule word.
    always_comb begin
        n_w_new  = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
        n_choose = (r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]);
        n_major  = (r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]);
        n_tmp1   = r_s[7] + big_sigma1(r_s[4]) + n_choose + round_k(r_round) + r_w[0];
        n_tmp2   = big_sigma0(r_s[0]) + n_major;
    end

    // Sequencer: init resets the chain, or load, 64 rounds, then fold the state in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_hash <= HASH_IV;
        end else if (i_ctl.init) begin
            r_hash <= HASH_IV;
        end else if (i_ctl.start) begin
            r_s     <= r_hash;
            r_w     <= i_block;
            r_round <= '0;
            r_busy  <= 1'b1;
            r_fin   <= 1'b0;
        end else if (r_busy) begin
            if (!r_fin) begin
                r_s     <= {r_s[6:4], r_s[3] + n_tmp1, r_s[2:0], n_tmp1 + n_tmp2};
                r_w     <= {n_w_new, r_w[15:1]};
                r_round <= r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    r_fin <= 1'b1;
                end
            end else begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + r_s[i];
                end
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_hash = r_hash;

endmodule

### rtl/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher: byte packing, padding and digest output.
//
// Input channel (i_valid/o_ready): one beat carries at most one message byte
// (i_data_byte when i_byte_present is 1) and may close the message
// (i_message_end). A beat with neither flag is accepted and ignored.
// Output channel (o_valid/i_ready): eight beats per message, digest word 0
// (most significant) first; o_digest_last marks word 7.
// The beat that fills a 64-byte block starts the compression unit, which runs
// one round per cycle; o_ready stays low through the registered start, the
// load, 64 rounds, the chain update and the exit from the compress state.
// The end beat starts padding, pushed one byte per cycle, apart from waits for
// compression, through the same packer: 0x80, zeros up to byte 56 of a block,
// then 8 length bytes, with one or two block compressions. If the end beat
// leaves 56 or more bytes in the current block, padding adds an extra block.
// An end beat whose byte fills a block first waits for that block's compression.
// When the receiver stalls, the digest word and index hold until taken.
// After the last digest beat the chain value and byte count return to their
// reset values. Reset (synchronous, active low) clears all control state and
// loads the initial hash.
module sha256_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_message_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_last
);
    import shamh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_COMP,
        S_OUT
    } t_state;

    t_state      r_state;
    logic [5:0]  r_pos;
    logic [60:0] r_byte_count;
    logic [23:0] r_word;
    t_blk        r_blk;
    logic        r_ending;
    logic        r_pad_first;
    logic [63:0] r_len;
    logic [2:0]  r_len_cnt;
    logic        r_len_done;
    logic [2:0]  r_out_idx;
    t_core_ctl   r_ctl;

    logic        n_push;
    logic [7:0]  n_push_byte;
    logic        n_wrap;
    t_core_ctl   n_ctl;
    logic        core_busy;
    t_hash       core_hash;

    shamh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .i_block (r_blk),
        .o_busy  (core_busy),
        .o_hash  (core_hash)
    );

    // Byte source for the packer: message bytes, padding or length bytes.
    always_comb begin
        n_push      = 1'b0;
        n_push_byte = '0;
        unique case (r_state)
            S_IDLE: begin
                n_push      = i_valid && i_byte_present;
                n_push_byte = i_data_byte;
            end
            S_PAD: begin
                n_push      = r_pad_first || (r_pos != PAD_STOP);
                n_push_byte = r_pad_first ? PAD_BYTE : 8'h00;
            end
            S_LEN: begin
                n_push      = 1'b1;
                n_push_byte = r_len[63:56];
            end
            default: begin
                n_push = 1'b0;
            end
        endcase
        n_wrap = n_push && (r_pos == LAST_ROUND);

        // A full block starts the compression unit; a taken last word restores the chain.
        n_ctl.start = n_wrap || ((r_state == S_LEN) && (r_len_cnt == LAST_WORD));
        n_ctl.init  = (r_state == S_OUT) && i_ready && (r_out_idx == LAST_WORD);
    end

    // Sequencer, byte packer and block buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos        <= '0;
            r_byte_count <= '0;
            r_ending     <= 1'b0;
            r_pad_first  <= 1'b0;
            r_len_done   <= 1'b0;
            r_len_cnt    <= '0;
            r_out_idx    <= '0;
            r_ctl        <= '0;
        end else begin
            r_ctl <= n_ctl;

            // Pack bytes big-endian; every fourth byte shifts a word into the block.
            if (n_push) begin
                r_pos  <= r_pos + 6'd1;
                r_word <= {r_word[15:0], n_push_byte};
                if (r_pos[1:0] == 2'b11) begin
                    r_blk <= {{r_word, n_push_byte}, r_blk[15:1]};
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_byte_present) begin
                            r_byte_count <= r_byte_count + 61'd1;
                        end
                        if (i_message_end) begin
                            r_ending    <= 1'b1;
                            r_pad_first <= 1'b1;
                        end
                        if (n_wrap) begin
                            r_state <= S_COMP;
                        end else if (i_message_end) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (n_push) begin
                        r_pad_first <= 1'b0;
                        if (n_wrap) begin
                            r_state <= S_COMP;
                        end
                    end else begin
                        r_state   <= S_LEN;
                        r_len     <= {r_byte_count, 3'b000};
                        r_len_cnt <= '0;
                    end
                end
                S_LEN: begin
                    r_len     <= {r_len[55:0], 8'h00};
                    r_len_cnt <= r_len_cnt + 3'd1;
                    if (r_len_cnt == LAST_WORD) begin
                        r_len_done <= 1'b1;
                        r_state    <= S_COMP;
                    end
                end
                S_COMP: begin
                    if (!r_ctl.start && !core_busy) begin
                        if (r_len_done) begin
                            r_state   <= S_OUT;
                            r_out_idx <= '0;
                        end else if (r_ending) begin
                            r_state <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == LAST_WORD) begin
                            r_state      <= S_IDLE;
                            r_pos        <= '0;
                            r_byte_count <= '0;
                            r_ending     <= 1'b0;
                            r_len_done   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Handshake and digest outputs.
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = core_hash[r_out_idx];
    assign o_word_index  = r_out_idx;
    assign o_digest_last = (r_out_idx == LAST_WORD);

`ifndef SYNTHESIS
    // The compression unit only runs while the sequencer waits for it.
    a_busy_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_busy |-> (r_state == S_COMP))
        else $error("compression unit busy outside the compress state");

    // Length bytes always land in the last eight bytes of a block.
    a_len_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN) |-> (r_pos[5:3] == 3'b111) && (r_pos[2:0] == r_len_cnt))
        else $error("length bytes out of place");

    // The digest is only shown once the final block has been compressed.
    a_out_after_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_len_done && !core_busy)
        else $error("digest shown before final compression");

    // A taken last word returns the block to idle with a fresh chain.
    a_last_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_digest_last) |=> o_ready && r_ctl.init && (r_pos == 6'd0))
        else $error("block did not restart after the digest");
`endif

endmodule

### bench/sha256_message_hasher_checker.sv
// Scoreboard for the SHA-256 message hasher: predicts digests from input beats and checks outputs.
`timescale 1ns / 100ps

module sha256_message_hasher_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_message_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_digest_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_checked
);

    // One expected digest beat.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    localparam logic [0:7][31:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int         LEN_FIELD_POS = 56;

    // Shadow copy of the hasher state.
    logic [31:0]  hash_state [8];
    logic [31:0]  msg_block [16];
    logic [60:0]  msg_bytes;

    t_digest_beat digest_q [$];
    int           fail_cnt;
    int           words_cnt;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        ror32 = dbl[31:0];
    endfunction

    function automatic void clear_hash_state();
        for (int i = 0; i < 8; i++) hash_state[i] = IV_WORDS[i];
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
        msg_bytes = '0;
    endfunction

    // Places one byte at block offset pos, big-endian within its word.
    function automatic void place_byte(input int pos, input logic [7:0] val);
        msg_block[pos / 4][8 * (3 - (pos % 4)) +: 8] = val;
    endfunction

    // Runs the 64-round compression of msg_block into hash_state.
    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] s [8];
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] ch;
        logic [31:0] maj;
        for (int r = 0; r < 16; r++) w[r] = msg_block[r];
        for (int r = 16; r < 64; r++) begin
            w[r] = (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                 + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
        end
        for (int r = 0; r < 8; r++) s[r] = hash_state[r];
        for (int r = 0; r < 64; r++) begin
            ch  = (s[4] & s[5]) ^ (~s[4] & s[6]);
            maj = (s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]);
            t1  = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25)) + ch
                + ROUND_K[r] + w[r];
            t2  = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22)) + maj;
            s[7] = s[6];
            s[6] = s[5];
            s[5] = s[4];
            s[4] = s[3] + t1;
            s[3] = s[2];
            s[2] = s[1];
            s[1] = s[0];
            s[0] = t1 + t2;
        end
        for (int r = 0; r < 8; r++) hash_state[r] = hash_state[r] + s[r];
    endfunction

    // Absorbs one accepted input beat; a message end queues the eight digest words.
    function automatic void absorb_beat(input logic [7:0] data, input logic present,
                                        input logic ending);
        int           pos;
        logic [63:0]  bit_len;
        t_digest_beat beat;
        if (present) begin
            place_byte(int'(msg_bytes[5:0]), data);
            msg_bytes = msg_bytes + 61'd1;
            if (msg_bytes[5:0] == 6'd0) compress_block();
        end
        if (!ending) return;
        // Padding: marker byte, zero fill, and an extra block if the length will not fit.
        pos = int'(msg_bytes[5:0]);
        place_byte(pos, PAD_MARK);
        for (int k = pos + 1; k < 64; k++) place_byte(k, 8'h00);
        if (pos >= LEN_FIELD_POS) begin
            compress_block();
            for (int i = 0; i < 16; i++) msg_block[i] = '0;
        end
        bit_len = {msg_bytes, 3'b000};
        msg_block[14] = bit_len[63:32];
        msg_block[15] = bit_len[31:0];
        compress_block();
        for (int k = 0; k < 8; k++) begin
            beat.word  = hash_state[k];
            beat.index = 3'(k);
            beat.last  = (k == 7);
            digest_q.push_back(beat);
        end
        clear_hash_state();
    endfunction

    // Output beats are checked before the input beat of the same edge is absorbed.
    always @(posedge i_clk) begin
        t_digest_beat want;
        if (!i_rst_n) begin
            clear_hash_state();
            digest_q.delete();
            fail_cnt  = 0;
            words_cnt = 0;
        end else begin
            if (i_out_valid === 1'b1 && i_out_ready) begin
                words_cnt++;
                if (digest_q.size() == 0) begin
                    $error("Digest beat with nothing expected: word %h index %0d",
                           i_digest_word, i_word_index);
                    fail_cnt++;
                end else begin
                    want = digest_q.pop_front();
                    if (i_digest_word !== want.word) begin
                        $error("digest_word: expected %h, got %h", want.word, i_digest_word);
                        fail_cnt++;
                    end
                    if (i_word_index !== want.index) begin
                        $error("word_index: expected %0d, got %0d", want.index, i_word_index);
                        fail_cnt++;
                    end
                    if (i_digest_last !== want.last) begin
                        $error("digest_last: expected %0b, got %0b", want.last, i_digest_last);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready === 1'b1) begin
                absorb_beat(i_data_byte, i_byte_present, i_message_end);
            end
        end
        o_fail_count    <= fail_cnt;
        o_pending       <= digest_q.size();
        o_words_checked <= words_cnt;
    end

endmodule

### bench/sha256_message_hasher_tb.sv
// Testbench top for the SHA-256 message hasher: clock, reset, message stimulus and verdict.
`timescale 1ns / 100ps

module sha256_message_hasher_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 150;
    localparam int DRAIN_CYCLES = 250;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_message_end = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_digest_last;

    int fail_count;
    int pending_words;
    int words_checked;

    int send_idle_pct = 23;
    int recv_idle_pct = 54;
    int cycle_cnt = 0;
    int msg_cnt = 0;
    int byte_cnt = 0;
    int idle_cnt = 0;

    sha256_message_hasher u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_message_end  (i_message_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_digest_last  (o_digest_last)
    );

    sha256_message_hasher_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_data_byte     (i_data_byte),
        .i_byte_present  (i_byte_present),
        .i_message_end   (i_message_end),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_digest_word   (o_digest_word),
        .i_word_index    (o_word_index),
        .i_digest_last   (o_digest_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words),
        .o_words_checked (words_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drives one input beat, with random gaps before it, and waits for its acceptance.
    task automatic send_beat(input logic [7:0] data, input logic present, input logic ending);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= data;
        i_byte_present <= present;
        i_message_end  <= ending;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        if (present) byte_cnt++;
        if (!present && !ending) idle_cnt++;
        if (ending) msg_cnt++;
    endtask

    // Holds the sender off until every expected digest word has been taken.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    // Sends a message of random bytes with occasional idle beats, ending on the last byte or on a separate end beat.
    task automatic send_message(input int len, input bit split_end);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9, 0) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, (i == len - 1) && !split_end);
        end
        if (len == 0 || split_end) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int rand_bytes;
        int len;
        bit first_long;
        rand_bytes = 0;
        first_long = 1'b1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle beat, empty message, "abc", byte extremes, split end markers.
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'ha5, 1'b0, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h5a, 1'b0, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hff, 1'b0, 1'b1);
        hold_until_drained();

        // Random messages: mostly short, with occasional ones spanning block and padding edges.
        while (rand_bytes < RANDOM_BYTES) begin
            if (rand_bytes < RANDOM_BYTES / 3) begin
                send_idle_pct = 23;
                recv_idle_pct = 54;
            end else if (rand_bytes < 2 * RANDOM_BYTES / 3) begin
                send_idle_pct = 54;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (first_long) begin
                // Length that pushes the length field into an extra padding block.
                len = $urandom_range(63, 56);
                first_long = 1'b0;
            end else if ($urandom_range(11, 0) == 0) begin
                len = $urandom_range(70, 52);
            end else begin
                len = $urandom_range(12, 0);
            end
            send_message(len, 1'($urandom_range(1, 0)));
            rand_bytes += len;
            if ($urandom_range(7, 0) == 0) hold_until_drained();
        end

        // Wind down: wait for all digests, then let the block sit to catch stray beats.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages: %0d data bytes, %0d idle beats, %0d digest words checked.",
                 msg_cnt, byte_cnt, idle_cnt, words_checked);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
